/* rtl/core/osmd_pkg.sv */
// Package for the overflow-safe multiply-divide block.
// Holds the operand width, status codes and the structs between top level and engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package osmd_pkg;

   localparam int FIELD_W = 64;
   localparam int WIDTH   = 64;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } osmd_status_type;

   typedef struct packed {
      logic start;
      logic ack;
      logic sgn;
   } osmd_ctrl_type;

   typedef struct packed {
      logic ready;
      logic valid;
   } osmd_stat_type;

   typedef struct packed {
      logic [WIDTH-1:0] quotient;
      logic [WIDTH-1:0] remainder;
      osmd_status_type  status;
   } osmd_result_type;

endpackage

`default_nettype wire

/* rtl/core/osmd_engine.sv */
// Bit-serial engine: shift-add multiply, then restoring divide of the double-width product.
// Depends on osmd_pkg for widths, status codes and the control structs.
`timescale 1ns / 1ps
`default_nettype none

module osmd_engine (
   input  wire                          clock,
   input  wire                          reset,
   input  osmd_pkg::osmd_ctrl_type      ctrl,
   input  wire  [osmd_pkg::WIDTH-1:0]   op_a,
   input  wire  [osmd_pkg::WIDTH-1:0]   op_b,
   input  wire  [osmd_pkg::WIDTH-1:0]   op_d,
   output osmd_pkg::osmd_stat_type      stat,
   output osmd_pkg::osmd_result_type    result
);
   import osmd_pkg::*;

   localparam int CNT_W = $clog2(2 * WIDTH);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_PREP = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   function automatic logic [WIDTH-1:0] magnitude(input logic [WIDTH-1:0] v, input logic sgn);
      magnitude = (sgn && v[WIDTH-1]) ? (~v + {{(WIDTH-1){1'b0}}, 1'b1}) : v;
   endfunction

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WIDTH-1:0]  a_ff, a_in;
   logic [WIDTH-1:0]  d_ff, d_in;
   logic [WIDTH-1:0]  hi_ff, hi_in;
   logic [2*WIDTH-1:0] n_ff, n_in;
   logic              pn_ff, pn_in;
   logic              nd_ff, nd_in;
   logic              sgn_ff, sgn_in;
   logic              dz_ff, dz_in;
   logic              nz_ff, nz_in;
   osmd_result_type   res_ff, res_in;

   logic [WIDTH:0]    mul_sum;
   logic              div_carry;
   logic [WIDTH-1:0]  div_shift;
   logic [WIDTH+1:0]  div_diff;
   logic              div_ge;
   logic [WIDTH-1:0]  d_mag;
   logic [WIDTH-1:0]  qlo;
   logic              pneg, qneg, ovf;
   logic [WIDTH-1:0]  lim;

   always_comb begin
      mul_sum   = {1'b0, hi_ff} + {1'b0, (n_ff[0] ? a_ff : {WIDTH{1'b0}})};
      div_carry = hi_ff[WIDTH-1];
      div_shift = {hi_ff[WIDTH-2:0], n_ff[2*WIDTH-1]};
      div_diff  = {1'b0, div_carry, div_shift} - {2'b00, d_ff};
      div_ge    = ~div_diff[WIDTH+1];
      d_mag     = magnitude(op_d, ctrl.sgn);
      qlo       = n_ff[WIDTH-1:0];
      pneg      = pn_ff && nz_ff;
      qneg      = (pneg != nd_ff) && (|n_ff);
      lim       = {1'b0, {(WIDTH-1){1'b1}}} + {{(WIDTH-1){1'b0}}, qneg};
      ovf       = (|n_ff[2*WIDTH-1:WIDTH]) || (sgn_ff && (qlo > lim));
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      d_in     = d_ff;
      hi_in    = hi_ff;
      n_in     = n_ff;
      pn_in    = pn_ff;
      nd_in    = nd_ff;
      sgn_in   = sgn_ff;
      dz_in    = dz_ff;
      nz_in    = nz_ff;
      res_in   = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               a_in     = magnitude(op_a, ctrl.sgn);
               n_in     = {{WIDTH{1'b0}}, magnitude(op_b, ctrl.sgn)};
               d_in     = d_mag;
               hi_in    = '0;
               pn_in    = ctrl.sgn && (op_a[WIDTH-1] != op_b[WIDTH-1]);
               nd_in    = ctrl.sgn && op_d[WIDTH-1];
               sgn_in   = ctrl.sgn;
               dz_in    = ~(|d_mag);
               cnt_in   = CNT_W'(WIDTH - 1);
               state_in = (~(|d_mag)) ? ST_FIN : ST_MUL;
            end
         end
         ST_MUL: begin
            hi_in  = mul_sum[WIDTH:1];
            n_in   = {n_ff[2*WIDTH-1:WIDTH], mul_sum[0], n_ff[WIDTH-1:1]};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            nz_in = (|hi_ff) || (|n_ff[WIDTH-1:0]);
            if (hi_ff < d_ff) begin
               n_in   = {n_ff[WIDTH-1:0], {WIDTH{1'b0}}};
               cnt_in = CNT_W'(WIDTH - 1);
            end else begin
               n_in   = {hi_ff, n_ff[WIDTH-1:0]};
               hi_in  = '0;
               cnt_in = CNT_W'(2 * WIDTH - 1);
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            hi_in  = div_ge ? div_diff[WIDTH-1:0] : div_shift;
            n_in   = {n_ff[2*WIDTH-2:0], div_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (dz_ff) begin
               res_in.quotient  = '0;
               res_in.remainder = '0;
               res_in.status    = STATUS_DIV_ZERO;
            end else begin
               res_in.quotient  = qneg ? (~qlo + {{(WIDTH-1){1'b0}}, 1'b1}) : qlo;
               res_in.remainder = pneg ? (~hi_ff + {{(WIDTH-1){1'b0}}, 1'b1}) : hi_ff;
               res_in.status    = ovf ? STATUS_OVERFLOW : STATUS_OK;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctrl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      d_ff   <= d_in;
      hi_ff  <= hi_in;
      n_ff   <= n_in;
      pn_ff  <= pn_in;
      nd_ff  <= nd_in;
      sgn_ff <= sgn_in;
      dz_ff  <= dz_in;
      nz_ff  <= nz_in;
      res_ff <= res_in;
   end

   assign stat.ready = (state_ff == ST_IDLE);
   assign stat.valid = (state_ff == ST_DONE);
   assign result     = res_ff;

   // partial remainder stays below the divisor through the divide
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (hi_ff < d_ff))
      else $error("partial remainder not below divisor");

   a_no_zero_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP) |-> !dz_ff)
      else $error("zero divisor reached the divide");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (stat.valid && !ctrl.ack) |=> (stat.valid && $stable(res_ff)))
      else $error("result dropped before transfer");

endmodule

`default_nettype wire

/* rtl/core/overflow_safe_multiply_divide.sv */
// Top level of the overflow-safe multiply-divide block: handshakes, mode register, result register.
// Depends on osmd_pkg and osmd_engine.
// A request is taken while the engine is idle; it then runs the shift-add multiply loop,
// a prepare step, the restoring divide loop (longer when the high product word is not below
// the divisor; WIDTH = 64), a finish step and the done state; a zero divisor goes straight to
// the finish step. The next request is taken while a finished response waits in rsp_ff.
// Reset (synchronous, active high): engine idle, response register empty, signed_mode = 1.
`timescale 1ns / 1ps
`default_nettype none

module overflow_safe_multiply_divide (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [osmd_pkg::FIELD_W-1:0]  req_multiplicand,
   input  wire  [osmd_pkg::FIELD_W-1:0]  req_multiplier,
   input  wire  [osmd_pkg::FIELD_W-1:0]  req_divisor,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [osmd_pkg::FIELD_W-1:0]  rsp_quotient,
   output logic [osmd_pkg::FIELD_W-1:0]  rsp_remainder,
   output logic [1:0]                    rsp_status,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire                           csr_wdata
);
   import osmd_pkg::*;

   logic            signed_mode_ff, signed_mode_in;
   logic            rsp_valid_ff, rsp_valid_in;
   osmd_result_type rsp_ff, rsp_in;
   osmd_ctrl_type   ctrl;
   osmd_stat_type   stat;
   osmd_result_type eng_result;
   logic            load;

   assign csr_ready = 1'b1;
   assign req_ready = stat.ready;
   assign load      = stat.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      ctrl.start = req_valid && stat.ready;
      ctrl.ack   = load;
      ctrl.sgn   = signed_mode_ff;
   end

   always_comb begin
      signed_mode_in = signed_mode_ff;
      if (csr_valid) begin
         signed_mode_in = csr_wdata;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      priority if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         signed_mode_ff <= signed_mode_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   osmd_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .op_a   (req_multiplicand[WIDTH-1:0]),
      .op_b   (req_multiplier[WIDTH-1:0]),
      .op_d   (req_divisor[WIDTH-1:0]),
      .stat   (stat),
      .result (eng_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_quotient  = FIELD_W'(rsp_ff.quotient);
   assign rsp_remainder = FIELD_W'(rsp_ff.remainder);
   assign rsp_status    = rsp_ff.status;

endmodule

`default_nettype wire
